/* rtl/blpc_pkg.sv */
// Shared types and constants for the bitmap line to planar converter.
package blpc_pkg;

  localparam int unsigned NumPix   = 8;
  localparam int unsigned PixW     = 8;
  localparam int unsigned AddrW    = 11;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned LineW    = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PlaneIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEST_BASE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_MODE = 2'd1;

  // color modes
  localparam logic [ModeW-1:0] MODE_8BPP = 2'd0;
  localparam logic [ModeW-1:0] MODE_4BPP = 2'd1;
  localparam logic [ModeW-1:0] MODE_2BPP = 2'd2;

  // index of the final plane per mode
  localparam logic [PlaneIdxW-1:0] LAST_PLANE_8BPP = 3'd7;
  localparam logic [PlaneIdxW-1:0] LAST_PLANE_4BPP = 3'd3;
  localparam logic [PlaneIdxW-1:0] LAST_PLANE_2BPP = 3'd1;

  typedef logic [PixW-1:0]  pixel_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    pixel_t [NumPix-1:0]   px;
    addr_t                 base;
    logic [PlaneIdxW-1:0]  last_plane;
  } row_t;

  typedef struct packed {
    addr_t     addr;
    logic [7:0] data;
  } plane_t;

endpackage

/* rtl/blpc_lane.sv */
// One plane lane: gathers bit PLANE of every pixel and forms its buffer address.
module blpc_lane #(
  parameter int unsigned PLANE = 0
) (
  input  blpc_pkg::row_t   row,
  output blpc_pkg::plane_t result
);
  import blpc_pkg::*;

  // planes pair up: bits 2..1 step by 16 bytes, bit 0 picks the odd byte
  localparam addr_t PlaneOff = addr_t'(((PLANE / 2) * 16) + (PLANE % 2));

  always_comb begin
    for (int b = 0; b < NumPix; b++) begin
      result.data[NumPix-1-b] = row.px[b][PLANE];
    end
    result.addr = row.base + PlaneOff;
  end

endmodule

/* rtl/blpc_merge.sv */
// Merge stage: latches all lane results, emits a plane byte per cycle unless stalled.
module blpc_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  blpc_pkg::plane_t [blpc_pkg::NumPix-1:0] lanes,
  input  logic [blpc_pkg::PlaneIdxW-1:0]      last_plane,
  output logic                                load_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [blpc_pkg::AddrW-1:0]          write_address,
  output logic [7:0]                          write_data,
  output logic                                last
);
  import blpc_pkg::*;

  plane_t [NumPix-1:0]  held;
  logic [PlaneIdxW-1:0] held_last;
  logic [PlaneIdxW-1:0] idx;
  logic                 busy;
  logic                 fire;

  assign last          = (idx == held_last);
  assign fire          = busy && out_ready;
  assign load_ready    = !busy || (out_ready && last);
  assign out_valid     = busy;
  assign write_address = held[idx].addr;
  assign write_data    = held[idx].data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load && load_ready) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      // advance through planes, drop on the final one
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      held      <= lanes;
      held_last <= last_plane;
    end
  end

endmodule

/* rtl/bitmap_line_to_planar_convert_unit.sv */
// Top level of the bitmap line to planar converter.
//
// Input channel: one request carries a row of eight packed pixels, pixel_0
// leftmost, accepted when in_valid and in_ready are both high. Output channel:
// one request per plane byte (write_address, write_data, last), accepted when
// out_valid and out_ready are both high; last marks the final plane of a row.
// Color mode 0 gives 8 plane bytes per row, mode 1 gives 4, modes 2 and 3 give 2.
// Eight lanes transpose all planes of a row at once; the merge stage then
// emits one plane byte per cycle while out_ready is high, so the output
// port sets the sustained rate. out_valid for the first plane byte rises once
// the row has passed the row register and been loaded into the merge stage.
// A row register in front of the merge stage takes the next row while
// the current one is still draining.
// When the receiver stalls, the current plane byte holds, then the row
// register fills and in_ready drops. Reset clears the line counter, both
// configuration registers and all valid flags. Configuration writes via cfg_write,
// cfg_index and cfg_data apply to rows accepted later; unknown indexes are dropped.
module bitmap_line_to_planar_convert_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [blpc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [blpc_pkg::AddrW-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      pixel_0,
  input  logic [7:0]                      pixel_1,
  input  logic [7:0]                      pixel_2,
  input  logic [7:0]                      pixel_3,
  input  logic [7:0]                      pixel_4,
  input  logic [7:0]                      pixel_5,
  input  logic [7:0]                      pixel_6,
  input  logic [7:0]                      pixel_7,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [blpc_pkg::AddrW-1:0]      write_address,
  output logic [7:0]                      write_data,
  output logic                            last
);
  import blpc_pkg::*;

  addr_t                dest_base;
  logic [ModeW-1:0]     color_mode;
  logic [LineW-1:0]     line_count;

  row_t                 row_next;
  row_t                 row;
  logic                 row_valid;
  logic                 merge_ready;
  logic                 in_fire;
  addr_t                aligned;
  addr_t                band_off;
  addr_t                line_off;
  plane_t [NumPix-1:0]  lanes;

  assign in_ready = !row_valid || merge_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_base  <= '0;
      color_mode <= MODE_8BPP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEST_BASE:  dest_base  <= cfg_data;
        CFG_COLOR_MODE: color_mode <= cfg_data[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // align base to a two-character block; upper half of the lines sits past it
  always_comb begin
    unique case (color_mode)
      MODE_8BPP: begin
        aligned             = {dest_base[AddrW-1:7], 7'b0};
        band_off            = {4'b0, line_count[3], 6'b0};
        row_next.last_plane = LAST_PLANE_8BPP;
      end
      MODE_4BPP: begin
        aligned             = {dest_base[AddrW-1:6], 6'b0};
        band_off            = {5'b0, line_count[3], 5'b0};
        row_next.last_plane = LAST_PLANE_4BPP;
      end
      default: begin
        aligned             = {dest_base[AddrW-1:5], 5'b0};
        band_off            = {6'b0, line_count[3], 4'b0};
        row_next.last_plane = LAST_PLANE_2BPP;
      end
    endcase
    line_off      = {7'b0, line_count[2:0], 1'b0};
    row_next.base = aligned + band_off + line_off;
    row_next.px   = {pixel_7, pixel_6, pixel_5, pixel_4,
                     pixel_3, pixel_2, pixel_1, pixel_0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= 1'b0;
      line_count <= '0;
    end else begin
      if (in_fire) begin
        row_valid  <= 1'b1;
        line_count <= line_count + 1'b1;
      end else if (merge_ready) begin
        row_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row <= row_next;
    end
  end

  for (genvar p = 0; p < NumPix; p++) begin : g_lane
    blpc_lane #(
      .PLANE(p)
    ) u_lane (
      .row   (row),
      .result(lanes[p])
    );
  end

  blpc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (row_valid),
    .lanes        (lanes),
    .last_plane   (row.last_plane),
    .load_ready   (merge_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_address(write_address),
    .write_data   (write_data),
    .last         (last)
  );

endmodule
